// ----- hdl/psbie_pkg.sv -----
// ----------------------------------------------------------------------------
// psbie_pkg: shared types and constants
// Request and result codes, status word constants and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package psbie_pkg;

	localparam int CFG_ADDR_W = 3;

	localparam logic [2:0] REQ_WRITE_STATUS = 3'd0;
	localparam logic [2:0] REQ_READ_STATE   = 3'd1;
	localparam logic [2:0] REQ_WRITE_SP     = 3'd2;
	localparam logic [2:0] REQ_EXC_ENTRY    = 3'd3;
	localparam logic [2:0] REQ_SET_LINE     = 3'd4;
	localparam logic [2:0] REQ_BOUNDARY     = 3'd5;

	localparam logic [1:0] LINE_CLEAR  = 2'd0;
	localparam logic [1:0] LINE_ASSERT = 2'd1;
	localparam logic [1:0] LINE_HOLD   = 2'd2;
	localparam logic [1:0] LINE_PULSE  = 2'd3;

	localparam logic [1:0] KIND_REPORT = 2'd0;
	localparam logic [1:0] KIND_WRITE  = 2'd1;
	localparam logic [1:0] KIND_FETCH  = 2'd2;

	localparam logic [31:0] PSW_RESET   = 32'h1000_0000;
	localparam logic [31:0] IS_MASK     = 32'h1000_0000;
	localparam logic [31:0] EL_MASK     = 32'h0300_0000;
	localparam logic [31:0] ENTRY_CLEAR = 32'h2B07_0000;
	localparam logic [31:0] ENTRY_SET   = 32'h8000_0000;
	localparam logic [31:0] BASE_MASK   = 32'hFFFF_F000;
	localparam logic [8:0]  IRQ_VEC_OFS = 9'h040;
	localparam logic [8:0]  NMI_VECTOR  = 9'd2;

	localparam int IS_BIT   = 28;
	localparam int IE_BIT   = 18;
	localparam int EL_LSB   = 24;
	localparam int N_BANKS  = 5;

	typedef enum logic [1:0] {
		SEL_REPORT,
		SEL_PUSH_PSW,
		SEL_PUSH_PC,
		SEL_FETCH
	} res_sel_t;

	typedef struct packed {
		logic     capture;
		logic     exec;
		logic     emit;
		res_sel_t sel;
	} dp_cmd_t;

	typedef struct packed {
		logic take;
	} dp_status_t;

endpackage

// ----- hdl/psbie_cfg.sv -----
// ----------------------------------------------------------------------------
// psbie_cfg: configuration register file
// Holds the system base register behind a simple APB-style port.
// ----------------------------------------------------------------------------
module psbie_cfg
	import psbie_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	output logic [31:0]           system_base
);

	logic [31:0] base_q;
	logic        hit;

	assign hit         = (paddr[CFG_ADDR_W-1:2] == '0);
	assign pready      = 1'b1;
	assign system_base = base_q;
	assign prdata      = hit ? base_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= 32'd0;
		end else if (psel && penable && pwrite && hit) begin
			base_q <= pwdata;
		end
	end

endmodule

// ----- hdl/psbie_ctrl.sv -----
// ----------------------------------------------------------------------------
// psbie_ctrl: request sequencer
// Accepts a request, lets the datapath execute it, then issues either one
// status report or the three results of an interrupt entry.
// ----------------------------------------------------------------------------
module psbie_ctrl
	import psbie_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  dp_status_t status,
	output logic       busy,
	output dp_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_REPORT,
		ST_PUSH_PSW,
		ST_PUSH_PC,
		ST_FETCH
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE:     if (start) state_q <= ST_EXEC;
				ST_EXEC:     state_q <= status.take ? ST_PUSH_PSW : ST_REPORT;
				ST_REPORT:   state_q <= ST_IDLE;
				ST_PUSH_PSW: state_q <= ST_PUSH_PC;
				ST_PUSH_PC:  state_q <= ST_FETCH;
				ST_FETCH:    state_q <= ST_IDLE;
				default:     state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		cmd.capture = (state_q == ST_IDLE) && start;
		cmd.exec    = (state_q == ST_EXEC);
		cmd.emit    = 1'b0;
		cmd.sel     = SEL_REPORT;
		case (state_q)
			ST_REPORT: begin
				cmd.emit = 1'b1;
				cmd.sel  = SEL_REPORT;
			end
			ST_PUSH_PSW: begin
				cmd.emit = 1'b1;
				cmd.sel  = SEL_PUSH_PSW;
			end
			ST_PUSH_PC: begin
				cmd.emit = 1'b1;
				cmd.sel  = SEL_PUSH_PC;
			end
			ST_FETCH: begin
				cmd.emit = 1'b1;
				cmd.sel  = SEL_FETCH;
			end
			default: begin
				cmd.emit = 1'b0;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_exec_then_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> cmd.emit)
		else $error("execution not followed by a result");
	a_push_order: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.sel == SEL_PUSH_PSW) |=> (cmd.emit && cmd.sel == SEL_PUSH_PC))
		else $error("program counter push did not follow status push");
	a_capture_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (busy && !cmd.emit))
		else $error("accepted item not being executed");
`endif

endmodule

// ----- hdl/psbie_dp.sv -----
// ----------------------------------------------------------------------------
// psbie_dp: status word and stack bank datapath
// Holds the status word, the live stack pointer, the five stack banks and
// the interrupt line states, and forms the result fields.
// ----------------------------------------------------------------------------
module psbie_dp
	import psbie_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_status_t  status,
	input  logic [31:0] system_base,
	input  logic [2:0]  req_type,
	input  logic [31:0] value,
	input  logic        to_int_stack,
	input  logic [1:0]  entry_level,
	input  logic        line_is_nmi,
	input  logic [1:0]  line_state,
	input  logic [7:0]  irq_vector,
	input  logic [31:0] current_pc,
	output logic [1:0]  kind,
	output logic [31:0] psw_now,
	output logic [31:0] sp_now,
	output logic [31:0] old_psw,
	output logic [31:0] address,
	output logic [31:0] write_data,
	output logic        last
);

	function automatic logic [2:0] bank_of(input logic [31:0] w);
		logic [2:0] b;
		if (w[IS_BIT]) begin
			b = 3'd0;
		end else begin
			b = 3'd1 + {1'b0, w[EL_LSB+1:EL_LSB]};
		end
		return b;
	endfunction

	// Captured request
	logic [2:0]  req_q;
	logic [31:0] value_q;
	logic        isi_q;
	logic [1:0]  lvl_q;
	logic        nmi_q;
	logic [1:0]  ls_q;
	logic [7:0]  vec_q;
	logic [31:0] pc_q;

	// Architectural state
	logic [31:0] psw_q;
	logic [31:0] sp_q;
	logic [31:0] bank_q [N_BANKS];
	logic [1:0]  mline_q;
	logic        nmi_lvl_q;

	// Step results
	logic [31:0] old_psw_q;
	logic [31:0] push_addr_q;
	logic [31:0] vec_addr_q;

	logic        nmi_req, try_line, take, do_put, sw;
	logic [1:0]  line_in, mline_next;
	logic        nmi_next;
	logic [8:0]  vec_num;
	logic [31:0] put_word, diff, sp_mid, sp_fin, psw_mid, psw_fin;
	logic [2:0]  old_bank, new_bank;

	always_comb begin
		nmi_req  = (req_q == REQ_SET_LINE) && nmi_q;
		try_line = ((req_q == REQ_SET_LINE) && !nmi_q) || (req_q == REQ_BOUNDARY);
		line_in  = ((req_q == REQ_SET_LINE) && !nmi_q) ? ls_q : mline_q;

		if (nmi_req) begin
			take = (ls_q == LINE_ASSERT) ? !nmi_lvl_q : (ls_q != LINE_CLEAR);
		end else begin
			take = try_line && (line_in != LINE_CLEAR) && psw_q[IE_BIT];
		end

		mline_next = mline_q;
		if (try_line) begin
			if (line_in == LINE_CLEAR) begin
				mline_next = LINE_CLEAR;
			end else if (psw_q[IE_BIT]) begin
				mline_next = (line_in == LINE_ASSERT) ? LINE_ASSERT : LINE_CLEAR;
			end else begin
				mline_next = (line_in == LINE_PULSE) ? LINE_CLEAR : line_in;
			end
		end

		nmi_next = nmi_req ? (ls_q == LINE_ASSERT) : nmi_lvl_q;
		vec_num  = nmi_req ? NMI_VECTOR : ({1'b0, vec_q} + IRQ_VEC_OFS);

		do_put = (req_q == REQ_WRITE_STATUS) || (req_q == REQ_EXC_ENTRY) || take;
		if (req_q == REQ_WRITE_STATUS) begin
			put_word = value_q;
		end else if (req_q == REQ_EXC_ENTRY) begin
			put_word = (psw_q & ~ENTRY_CLEAR) | ENTRY_SET
				| ({30'd0, lvl_q} << EL_LSB) | ({31'd0, isi_q} << IS_BIT);
		end else begin
			put_word = psw_q | IS_MASK;
		end

		diff     = put_word ^ psw_q;
		sw       = do_put && (((diff & IS_MASK) != '0) ||
			(!psw_q[IS_BIT] && ((diff & EL_MASK) != '0)));
		old_bank = bank_of(psw_q);
		new_bank = bank_of(put_word);
		sp_mid   = sw ? bank_q[new_bank] : sp_q;

		if (req_q == REQ_WRITE_SP) begin
			sp_fin = value_q;
		end else if (take) begin
			sp_fin = sp_mid - 32'd8;
		end else begin
			sp_fin = sp_mid;
		end

		psw_mid = do_put ? put_word : psw_q;
		psw_fin = take ? ((psw_mid & ~ENTRY_CLEAR) | ENTRY_SET) : psw_mid;
	end

	assign status.take = take;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q   <= req_type;
			value_q <= value;
			isi_q   <= to_int_stack;
			lvl_q   <= entry_level;
			nmi_q   <= line_is_nmi;
			ls_q    <= line_state;
			vec_q   <= irq_vector;
			pc_q    <= current_pc;
		end
		if (cmd.exec) begin
			old_psw_q   <= psw_q;
			push_addr_q <= sp_mid - 32'd4;
			vec_addr_q  <= (system_base & BASE_MASK) | {21'd0, vec_num, 2'b00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psw_q     <= PSW_RESET;
			sp_q      <= 32'd0;
			mline_q   <= LINE_CLEAR;
			nmi_lvl_q <= 1'b0;
			for (int i = 0; i < N_BANKS; i++) begin
				bank_q[i] <= 32'd0;
			end
		end else if (cmd.exec) begin
			psw_q     <= psw_fin;
			sp_q      <= sp_fin;
			mline_q   <= mline_next;
			nmi_lvl_q <= nmi_next;
			if (sw) begin
				bank_q[old_bank] <= sp_q;
			end
		end
	end

	assign psw_now = psw_q;
	assign sp_now  = sp_q;
	assign old_psw = old_psw_q;

	always_comb begin
		case (cmd.sel)
			SEL_PUSH_PSW: begin
				kind       = KIND_WRITE;
				address    = push_addr_q;
				write_data = old_psw_q;
				last       = 1'b0;
			end
			SEL_PUSH_PC: begin
				kind       = KIND_WRITE;
				address    = sp_q;
				write_data = pc_q;
				last       = 1'b0;
			end
			SEL_FETCH: begin
				kind       = KIND_FETCH;
				address    = vec_addr_q;
				write_data = 32'd0;
				last       = 1'b1;
			end
			default: begin
				kind       = KIND_REPORT;
				address    = 32'd0;
				write_data = 32'd0;
				last       = 1'b1;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_push_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.sel == SEL_PUSH_PSW) |-> (push_addr_q - 32'd4 == sp_q))
		else $error("push addresses are not one word apart");
	a_fetch_word: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.sel == SEL_FETCH) |-> (psw_q[31] && psw_q[IS_BIT] && !psw_q[IE_BIT]))
		else $error("status word not in interrupt state at vector fetch");
`endif

endmodule

// ----- hdl/psw_stack_bank_interrupt_entry.sv -----
// ----------------------------------------------------------------------------
// psw_stack_bank_interrupt_entry: status word, banked stacks, interrupt entry
// Top level joining the configuration port, controller and datapath.
// ----------------------------------------------------------------------------
// Usage:
// A request is accepted on a rising edge with start high and busy low. The
// block then executes it and issues its results, each shown for exactly one
// cycle with strobe high; last marks the final result of the item.
// Ordinary requests give one status report: busy through the execute state
// and the report state. A taken interrupt gives a status push, a program
// counter push and a vector fetch, one after another, each in its own state.
// The single execute state updates the status word, the live stack pointer
// and at most one stack bank; one item is in flight at a time.
// The receiver cannot stall, so results never wait.
// The system base register is to be written by the user through the APB port
// only while idle; the block itself does not enforce this.
// Reset sets the architectural state: the status word selects the interrupt
// stack, the stack pointer, banks, lines and base register read zero.
// ----------------------------------------------------------------------------
module psw_stack_bank_interrupt_entry
	import psbie_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	input  logic                  start,
	output logic                  busy,
	input  logic [2:0]            req_type,
	input  logic [31:0]           value,
	input  logic                  to_int_stack,
	input  logic [1:0]            entry_level,
	input  logic                  line_is_nmi,
	input  logic [1:0]            line_state,
	input  logic [7:0]            irq_vector,
	input  logic [31:0]           current_pc,
	output logic                  strobe,
	output logic [1:0]            kind,
	output logic [31:0]           psw_now,
	output logic [31:0]           sp_now,
	output logic [31:0]           old_psw,
	output logic [31:0]           address,
	output logic [31:0]           write_data,
	output logic                  last
);

	logic [31:0] system_base;
	dp_cmd_t     cmd;
	dp_status_t  status;

	psbie_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.system_base (system_base)
	);

	psbie_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.busy   (busy),
		.cmd    (cmd)
	);

	psbie_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.system_base  (system_base),
		.req_type     (req_type),
		.value        (value),
		.to_int_stack (to_int_stack),
		.entry_level  (entry_level),
		.line_is_nmi  (line_is_nmi),
		.line_state   (line_state),
		.irq_vector   (irq_vector),
		.current_pc   (current_pc),
		.kind         (kind),
		.psw_now      (psw_now),
		.sp_now       (sp_now),
		.old_psw      (old_psw),
		.address      (address),
		.write_data   (write_data),
		.last         (last)
	);

	assign strobe = cmd.emit;

endmodule

// ----- bench/psw_stack_checker.sv -----
// ----------------------------------------------------------------------------
// psw_stack_checker: result predictor and comparator
// Watches the configuration port, the request handshake and the result
// strobe. For each accepted item it computes the status word, banked stack
// and interrupt entry results and compares each result with the oldest
// expected one. Failures are counted and handed to the bench top.
// ----------------------------------------------------------------------------
module psw_stack_checker
	import psbie_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	input  logic                  pready,
	input  logic                  start,
	input  logic                  busy,
	input  logic [2:0]            req_type,
	input  logic [31:0]           value,
	input  logic                  to_int_stack,
	input  logic [1:0]            entry_level,
	input  logic                  line_is_nmi,
	input  logic [1:0]            line_state,
	input  logic [7:0]            irq_vector,
	input  logic [31:0]           current_pc,
	input  logic                  strobe,
	input  logic [1:0]            kind,
	input  logic [31:0]           psw_now,
	input  logic [31:0]           sp_now,
	input  logic [31:0]           old_psw,
	input  logic [31:0]           address,
	input  logic [31:0]           write_data,
	input  logic                  last,
	output int                    mismatches,
	output int                    pending
);

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] psw_now;
		logic [31:0] sp_now;
		logic [31:0] old_psw;
		logic [31:0] address;
		logic [31:0] write_data;
		logic        last;
	} psw_result_t;

	logic [31:0] base_reg;
	logic [31:0] psw;
	logic [31:0] sp;
	logic [31:0] bank [N_BANKS];
	logic [1:0]  mask_line;
	logic        nmi_high;

	psw_result_t step_res [3];
	int          n_res;
	psw_result_t expected_results [$];
	psw_result_t seen;
	psw_result_t want;

	function automatic int bank_index(input logic [31:0] w);
		if (w[IS_BIT])
			return 0;
		return 1 + int'(w[EL_LSB +: 2]);
	endfunction

	function automatic string result_text(input psw_result_t r);
		return $sformatf("kind=%0d psw=%h sp=%h old=%h addr=%h data=%h last=%b",
			r.kind, r.psw_now, r.sp_now, r.old_psw, r.address, r.write_data, r.last);
	endfunction

	task automatic note_failure(input string msg);
		if (mismatches < 10)
			$display("ERROR %s", msg);
		mismatches++;
	endtask

	task automatic load_psw(input logic [31:0] nv);
		logic [31:0] diff;
		logic        swap;
		diff = nv ^ psw;
		swap = diff[IS_BIT] || (!psw[IS_BIT] && ((diff & EL_MASK) != 0));
		if (swap)
			bank[bank_index(psw)] = sp;
		psw = nv;
		if (swap)
			sp = bank[bank_index(psw)];
	endtask

	task automatic enter_interrupt(input logic [31:0] vec, input logic [31:0] pc);
		logic [31:0] saved;
		saved = psw;
		load_psw(psw | IS_MASK);
		sp = sp - 32'd4;
		step_res[0] = '{KIND_WRITE, 32'd0, 32'd0, 32'd0, sp, saved, 1'b0};
		sp = sp - 32'd4;
		step_res[1] = '{KIND_WRITE, 32'd0, 32'd0, 32'd0, sp, pc, 1'b0};
		psw = (psw & ~ENTRY_CLEAR) | ENTRY_SET;
		step_res[2] = '{KIND_FETCH, 32'd0, 32'd0, 32'd0,
			(base_reg & BASE_MASK) + vec * 32'd4, 32'd0, 1'b0};
		n_res = 3;
	endtask

	task automatic poll_mask_line(input logic [31:0] pc);
		if (mask_line == LINE_CLEAR)
			return;
		if (psw[IE_BIT]) begin
			if (mask_line != LINE_ASSERT)
				mask_line = LINE_CLEAR;
			enter_interrupt(32'(irq_vector) + 32'(IRQ_VEC_OFS), pc);
		end else if (mask_line == LINE_PULSE) begin
			mask_line = LINE_CLEAR;
		end
	endtask

	task automatic predict_psw_request();
		logic [31:0] prior;
		logic [31:0] nv;
		prior = psw;
		n_res = 0;
		case (req_type)
			REQ_WRITE_STATUS: load_psw(value);
			REQ_WRITE_SP: sp = value;
			REQ_EXC_ENTRY: begin
				nv = (psw & ~ENTRY_CLEAR) | (32'(entry_level) << EL_LSB) | ENTRY_SET;
				if (to_int_stack)
					nv = nv | IS_MASK;
				load_psw(nv);
			end
			REQ_SET_LINE: begin
				if (line_is_nmi) begin
					if (line_state == LINE_ASSERT) begin
						if (!nmi_high) begin
							nmi_high = 1'b1;
							enter_interrupt(32'(NMI_VECTOR), current_pc);
						end
					end else if (line_state == LINE_CLEAR) begin
						nmi_high = 1'b0;
					end else begin
						nmi_high = 1'b0;
						enter_interrupt(32'(NMI_VECTOR), current_pc);
					end
				end else begin
					mask_line = line_state;
					poll_mask_line(current_pc);
				end
			end
			REQ_BOUNDARY: poll_mask_line(current_pc);
			default: ;
		endcase
		if (n_res == 0) begin
			step_res[0] = '{KIND_REPORT, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0};
			n_res = 1;
		end
		for (int k = 0; k < n_res; k++) begin
			step_res[k].psw_now = psw;
			step_res[k].sp_now = sp;
			step_res[k].old_psw = prior;
			step_res[k].last = (k == n_res - 1);
			expected_results.push_back(step_res[k]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_reg = 32'd0;
			psw = PSW_RESET;
			sp = 32'd0;
			for (int i = 0; i < N_BANKS; i++)
				bank[i] = 32'd0;
			mask_line = LINE_CLEAR;
			nmi_high = 1'b0;
			expected_results.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (strobe) begin
				seen = '{kind, psw_now, sp_now, old_psw, address, write_data, last};
				if (expected_results.size() == 0) begin
					note_failure({"unexpected result: ", result_text(seen)});
				end else begin
					want = expected_results.pop_front();
					if (seen !== want)
						note_failure({"result mismatch\n  expected ", result_text(want),
							"\n  actual   ", result_text(seen)});
				end
			end
			if (psel && penable && pwrite && pready && paddr[CFG_ADDR_W-1:2] == 0)
				base_reg = pwdata;
			if (start && !busy)
				predict_psw_request();
			pending = expected_results.size();
		end
	end

endmodule

// ----- bench/psw_stack_bank_interrupt_entry_tb.sv -----
// ----------------------------------------------------------------------------
// psw_stack_bank_interrupt_entry_tb: bench top for the status word block
// Drives a directed set of stack switches, exception entries, line states
// and interrupt entries, then four random phases under different system
// base settings, with random gaps between items turned on and off. The checker instance
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module psw_stack_bank_interrupt_entry_tb;
	import psbie_pkg::*;

	localparam logic [2:0] REQ_SPARE_A = 3'd6;
	localparam logic [2:0] REQ_SPARE_B = 3'd7;
	localparam int         PHASE_ITEMS = 100;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [31:0] value;
		logic        to_int_stack;
		logic [1:0]  entry_level;
		logic        line_is_nmi;
		logic [1:0]  line_state;
		logic [7:0]  irq_vector;
		logic [31:0] current_pc;
	} psw_request_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;
	logic                  start;
	logic                  busy;
	logic [2:0]            req_type;
	logic [31:0]           value;
	logic                  to_int_stack;
	logic [1:0]            entry_level;
	logic                  line_is_nmi;
	logic [1:0]            line_state;
	logic [7:0]            irq_vector;
	logic [31:0]           current_pc;
	logic                  strobe;
	logic [1:0]            kind;
	logic [31:0]           psw_now;
	logic [31:0]           sp_now;
	logic [31:0]           old_psw;
	logic [31:0]           address;
	logic [31:0]           write_data;
	logic                  last;
	int                    mismatches;
	int                    pending;
	int                    items_sent;
	logic                  gaps_on;

	psw_stack_bank_interrupt_entry i_dut (.*);

	psw_stack_checker i_checker (.*);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic psw_request_t make_req(input logic [2:0] rt, input logic [31:0] v,
		input int isi, input int lvl, input int nmi, input logic [1:0] ls,
		input logic [7:0] vec, input logic [31:0] pc);
		return '{rt, v, 1'(isi), 2'(lvl), 1'(nmi), ls, vec, pc};
	endfunction

	function automatic psw_request_t random_req();
		psw_request_t r;
		r = '{3'($urandom_range(0, 7)), $urandom, 1'($urandom), 2'($urandom),
			1'($urandom), 2'($urandom), 8'($urandom), $urandom};
		return r;
	endfunction

	function automatic logic [31:0] random_psw();
		logic [31:0] w;
		w = $urandom;
		w[IE_BIT] = ($urandom_range(0, 3) != 0);
		w[IS_BIT] = 1'($urandom);
		return w;
	endfunction

	task automatic send_item(input psw_request_t r);
		int gap;
		gap = gaps_on ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		{req_type, value, to_int_stack, entry_level, line_is_nmi, line_state,
			irq_vector, current_pc} = r;
		start = 1'b1;
		while (busy)
			@(negedge clk);
		@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic write_base(input logic [31:0] data);
		start = 1'b0;
		while (pending != 0 || busy)
			@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		paddr = '0;
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic send_random_item();
		psw_request_t r;
		int pick;
		r = random_req();
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			r.req_type = REQ_WRITE_STATUS;
			r.value = random_psw();
		end else if (pick < 20) begin
			r.req_type = ($urandom_range(0, 2) == 0) ? REQ_READ_STATE :
				($urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B);
		end else if (pick < 28) begin
			r.req_type = REQ_WRITE_SP;
		end else if (pick < 36) begin
			r.req_type = REQ_EXC_ENTRY;
		end else if (pick < 56) begin
			r.req_type = REQ_SET_LINE;
			r.line_is_nmi = ($urandom_range(0, 2) == 0);
		end else if (pick < 70) begin
			r.req_type = REQ_BOUNDARY;
		end else begin
			r.req_type = REQ_WRITE_STATUS;
			r.value = random_psw();
			r.value[IE_BIT] = 1'b1;
			send_item(r);
			r = random_req();
			r.req_type = REQ_SET_LINE;
			r.line_is_nmi = 1'b0;
			send_item(r);
			repeat ($urandom_range(1, 3)) begin
				r = random_req();
				r.req_type = REQ_BOUNDARY;
				send_item(r);
			end
			return;
		end
		send_item(r);
	endtask

	initial begin
		#200000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		{req_type, value, to_int_stack, entry_level, line_is_nmi, line_state,
			irq_vector, current_pc} = '0;
		items_sent = 0;
		gaps_on = 1'b1;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_base(32'hFFFF_FFFF);
		send_item(make_req(REQ_READ_STATE, 32'h0, 0, 0, 0, LINE_CLEAR, 8'h00, 32'h0));
		send_item(make_req(REQ_WRITE_SP, 32'h0000_1000, 0, 0, 0, LINE_CLEAR, 8'h00, 32'h0));
		send_item(make_req(REQ_WRITE_STATUS, 32'h0000_0000, 0, 0, 0, LINE_CLEAR, 8'h00, 32'h0));
		send_item(make_req(REQ_WRITE_SP, 32'h0000_2000, 0, 0, 0, LINE_CLEAR, 8'h00, 32'h0));
		send_item(make_req(REQ_WRITE_STATUS, 32'h0300_0000, 0, 0, 0, LINE_CLEAR, 8'h00, 32'h0));
		send_item(make_req(REQ_WRITE_SP, 32'h0000_3000, 0, 0, 0, LINE_CLEAR, 8'h00, 32'h0));
		send_item(make_req(REQ_WRITE_STATUS, 32'h1300_0000, 0, 0, 0, LINE_CLEAR, 8'h00, 32'h0));
		send_item(make_req(REQ_WRITE_STATUS, 32'h1000_0000, 0, 0, 0, LINE_CLEAR, 8'h00, 32'h0));
		send_item(make_req(REQ_WRITE_STATUS, 32'h0004_0000, 0, 0, 0, LINE_CLEAR, 8'h00, 32'h0));
		send_item(make_req(REQ_SET_LINE, 32'h0, 0, 0, 0, LINE_ASSERT, 8'hFF, 32'hFFFF_FFFF));
		send_item(make_req(REQ_BOUNDARY, 32'h0, 0, 0, 0, LINE_CLEAR, 8'h00, 32'h1234_5678));
		send_item(make_req(REQ_WRITE_STATUS, 32'h0104_0000, 0, 0, 0, LINE_CLEAR, 8'h00, 32'h0));
		send_item(make_req(REQ_BOUNDARY, 32'h0, 0, 0, 0, LINE_CLEAR, 8'h00, 32'h0000_0000));
		send_item(make_req(REQ_WRITE_STATUS, 32'h0204_0000, 0, 0, 0, LINE_CLEAR, 8'h00, 32'h0));
		send_item(make_req(REQ_SET_LINE, 32'h0, 0, 0, 0, LINE_HOLD, 8'h00, 32'h8000_0000));
		send_item(make_req(REQ_SET_LINE, 32'h0, 0, 0, 0, LINE_PULSE, 8'h7F, 32'h0));
		send_item(make_req(REQ_BOUNDARY, 32'h0, 0, 0, 0, LINE_CLEAR, 8'h00, 32'h0));
		send_item(make_req(REQ_WRITE_SP, 32'h0000_0000, 0, 0, 0, LINE_CLEAR, 8'h00, 32'h0));
		send_item(make_req(REQ_SET_LINE, 32'h0, 0, 0, 1, LINE_ASSERT, 8'h00, 32'hFFFF_FFFF));
		send_item(make_req(REQ_SET_LINE, 32'h0, 0, 0, 1, LINE_ASSERT, 8'h00, 32'h0));
		send_item(make_req(REQ_SET_LINE, 32'h0, 0, 0, 1, LINE_CLEAR, 8'h00, 32'h0));
		send_item(make_req(REQ_SET_LINE, 32'h0, 0, 0, 1, LINE_HOLD, 8'h00, 32'h0000_0004));
		send_item(make_req(REQ_SET_LINE, 32'h0, 0, 0, 1, LINE_PULSE, 8'h00, 32'h0000_0008));
		send_item(make_req(REQ_EXC_ENTRY, 32'h0, 0, 3, 0, LINE_CLEAR, 8'h00, 32'h0));
		send_item(make_req(REQ_EXC_ENTRY, 32'h0, 1, 0, 0, LINE_CLEAR, 8'h00, 32'h0));
		send_item(make_req(REQ_SPARE_A, 32'hFFFF_FFFF, 1, 3, 1, LINE_PULSE, 8'hFF,
			32'hFFFF_FFFF));
		send_item(make_req(REQ_SPARE_B, 32'h0, 0, 0, 0, LINE_CLEAR, 8'h00, 32'h0));
		send_item(make_req(REQ_WRITE_STATUS, 32'hFFFF_FFFF, 0, 0, 0, LINE_CLEAR, 8'h00, 32'h0));

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: write_base($urandom);
				1: write_base(32'h0000_0000);
				2: write_base(32'hFFFF_FFFF);
				default: write_base($urandom);
			endcase
			gaps_on = (phase != 2);
			while (items_sent < 28 + (phase + 1) * PHASE_ITEMS) begin
				send_random_item();
				if ($urandom_range(0, 15) == 0)
					gaps_on = !gaps_on;
			end
		end

		start = 1'b0;
		while (pending != 0 || busy)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/psbie_pkg.sv
hdl/psbie_cfg.sv
hdl/psbie_ctrl.sv
hdl/psbie_dp.sv
hdl/psw_stack_bank_interrupt_entry.sv
bench/psw_stack_checker.sv
bench/psw_stack_bank_interrupt_entry_tb.sv
